FILE: design/rgbca_pkg.sv
// ============================================================================
// rgbca_pkg
// Shared types, register codes and constant tables for the RGB555 color
// adjust pipeline.
// ============================================================================
package rgbca_pkg;

    // Field widths.
    localparam int CHAN_IN_W  = 5;
    localparam int CHAN_OUT_W = 8;
    localparam int COLOR_IN_W = 3 * CHAN_IN_W;
    localparam int COLOR_OUT_W = 3 * CHAN_OUT_W;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_USE_RAMP   = 2'd0;
    localparam logic [1:0] REG_CONTRAST   = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd2;
    localparam logic [1:0] REG_GAMMA      = 2'd3;

    localparam logic [7:0] PERCENT_NEUTRAL = 8'd100;
    localparam logic [8:0] GAMMA_NEUTRAL   = 9'd100;

    // Fixed-point widths of the power-law step.
    localparam int LG_W      = 19;   // log2 difference, Q16
    localparam int DQ_W      = 22;   // scaled exponent, Q16
    localparam int Q_FRAC    = 30;   // fraction bits of the exp2 accumulator
    localparam int ACC_W     = Q_FRAC + 1;
    localparam int EXP_STEPS = 16;

    // Reciprocal constants for the two constant divisions.
    localparam logic [16:0] RECIP_255       = 17'd65793;     // floor(2^24 / 255)
    localparam int          RECIP_255_SHIFT = 24;
    localparam logic [25:0] RECIP_25        = 26'd42949672;  // floor(2^30 / 25)
    localparam int          RECIP_25_SHIFT  = 30;

    // Eight front stages, the exp2 multiplier chain and the output stage.
    localparam int PIPE_DEPTH = 9 + EXP_STEPS;

    typedef struct packed {
        logic       use_ramp;
        logic [7:0] contrast;
        logic [7:0] brightness;
        logic [8:0] gamma;
    } rgbca_cfg_t;

    typedef logic [LG_W-1:0]  lg_tab_t   [256];
    typedef logic [ACC_W-1:0] root_tab_t [EXP_STEPS];

    localparam logic [7:0] GAMMA_RAMP [32] = '{
        8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
        8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
        8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
        8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
    };

    // Log2 in Q16 by repeated squaring; used only to build constant tables.
    function automatic logic [LG_W-1:0] log2_q16(input logic [7:0] y);
        logic [2:0]  n;
        logic [63:0] m;
        logic [15:0] frac;
        n = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if ((int'(n) == i) && ((y >> (i + 1)) != 8'd0)) begin
                n = n + 3'd1;
            end
        end
        m = (64'(y) << 16) >> n;
        frac = '0;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 16;
            if (m >= 64'h2_0000) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return {n, frac};
    endfunction

    // Entry x holds log2(255) - log2(x); entry 0 is never used.
    function automatic lg_tab_t build_lg_tab();
        lg_tab_t         tab;
        logic [LG_W-1:0] top;
        top = log2_q16(8'd255);
        tab[0] = '0;
        for (int y = 1; y < 256; y++) begin
            tab[y] = top - log2_q16(8'(y));
        end
        return tab;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v = v_in;
        res = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Entry j is 2^(-2^(j-16)) in Q30, formed by repeated square roots of 0.5.
    function automatic root_tab_t build_root_tab();
        root_tab_t   tab;
        logic [63:0] s;
        s = 64'd1 << (Q_FRAC - 1);
        for (int j = EXP_STEPS - 1; j >= 0; j--) begin
            s = isqrt64(s << Q_FRAC);
            tab[j] = s[ACC_W-1:0];
        end
        return tab;
    endfunction

    localparam lg_tab_t   LG_TAB   = build_lg_tab();
    localparam root_tab_t ROOT_TAB = build_root_tab();

    function automatic logic [7:0] clamp_u8(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 12'sd0) begin
            res = 8'd0;
        end else if (v > 12'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

FILE: design/rgbca_channel.sv
// ============================================================================
// rgbca_channel
// Pipeline for one color channel: expansion or ramp, contrast, brightness
// and the fixed-point power-law gamma.
// ============================================================================
module rgbca_channel (
    input  logic                                clk,
    input  logic [rgbca_pkg::CHAN_IN_W-1:0]     chan_in,
    input  rgbca_pkg::rgbca_cfg_t               cfg,
    output logic [rgbca_pkg::CHAN_OUT_W-1:0]    chan_out
);

    localparam int STEPS = rgbca_pkg::EXP_STEPS;
    localparam int ACC_W = rgbca_pkg::ACC_W;
    localparam int DQ_W  = rgbca_pkg::DQ_W;
    localparam int QF    = rgbca_pkg::Q_FRAC;

    logic signed [8:0] contrast_c;
    assign contrast_c = $signed({1'b0, cfg.contrast}) - 9'sd100;

    // Stage 1: widen to 8 bits or look up the ramp.
    logic [7:0] x1_next, x1_reg;
    assign x1_next = cfg.use_ramp ? rgbca_pkg::GAMMA_RAMP[chan_in]
                                  : {chan_in, chan_in[4:2]};

    // Stage 2: contrast product.
    logic signed [17:0] prod2_next, prod2_reg;
    logic [7:0]         x2_reg;
    assign prod2_next = contrast_c * $signed({1'b0, x1_reg});

    // Stage 3: magnitude of the rounded numerator times 1/255.
    logic signed [18:0] num3;
    logic [16:0]        mag3_next, mag3_reg;
    logic [33:0]        prod3_next, prod3_reg;
    logic               neg3_reg;
    logic [7:0]         x3_reg;
    assign num3       = $signed({prod2_reg, 1'b0}) + 19'sd127;
    assign mag3_next  = num3[18] ? 17'(-num3) : 17'(num3);
    assign prod3_next = 34'(mag3_next) * 34'(rgbca_pkg::RECIP_255);

    // Stage 4: correct the quotient, truncate toward zero, apply contrast.
    logic [9:0]         q4_est, q4;
    logic [17:0]        q4_x255, rem4;
    logic signed [11:0] q4_signed, sum4;
    logic [7:0]         x4_next, x4_reg;
    always_comb
    begin
        q4_est    = prod3_reg[rgbca_pkg::RECIP_255_SHIFT +: 10];
        q4_x255   = {q4_est, 8'd0} - {8'd0, q4_est};
        rem4      = {1'b0, mag3_reg} - q4_x255;
        q4        = (rem4 >= 18'd255) ? q4_est + 10'd1 : q4_est;
        q4_signed = neg3_reg ? -$signed({2'b00, q4}) : $signed({2'b00, q4});
        sum4      = $signed({4'd0, x3_reg}) - $signed({{3{contrast_c[8]}}, contrast_c})
                    + q4_signed;
        x4_next   = (cfg.contrast != rgbca_pkg::PERCENT_NEUTRAL)
                    ? rgbca_pkg::clamp_u8(sum4) : x3_reg;
    end

    // Stage 5: brightness offset.
    logic signed [11:0] sum5;
    logic [7:0]         x5_next, x5_reg;
    assign sum5    = $signed({4'd0, x4_reg}) + $signed({4'd0, cfg.brightness}) - 12'sd100;
    assign x5_next = (cfg.brightness != rgbca_pkg::PERCENT_NEUTRAL)
                     ? rgbca_pkg::clamp_u8(sum5) : x4_reg;

    // Stage 6: log2 difference times the gamma setting.
    logic [27:0] prod6_next, prod6_reg;
    logic [7:0]  x6_reg;
    assign prod6_next = 28'(rgbca_pkg::LG_TAB[x5_reg]) * 28'(cfg.gamma);

    // Stage 7: rounded division by 100, done as a shift by 2 and a 1/25 product.
    logic [28:0] w7;
    logic [26:0] u7_next, u7_reg;
    logic [52:0] prod7_next, prod7_reg;
    logic [7:0]  x7_reg;
    assign w7         = {1'b0, prod6_reg} + 29'd50;
    assign u7_next    = w7[28:2];
    assign prod7_next = 53'(u7_next) * 53'(rgbca_pkg::RECIP_25);

    // Stage 8: correct the quotient to get the exponent.
    logic [22:0]     q8_est;
    logic [26:0]     q8_x25, rem8;
    logic [DQ_W-1:0] d8_next, d8_reg;
    logic [7:0]      x8_reg;
    always_comb
    begin
        q8_est  = prod7_reg[rgbca_pkg::RECIP_25_SHIFT +: 23];
        q8_x25  = 27'({q8_est, 4'd0}) + 27'({q8_est, 3'd0}) + 27'(q8_est);
        rem8    = u7_reg - q8_x25;
        d8_next = (rem8 >= 27'd25) ? DQ_W'(q8_est + 23'd1) : DQ_W'(q8_est);
    end

    // Stages 9 to 24: exp2 of the fractional exponent, one root constant each.
    logic [ACC_W-1:0] acc_reg  [STEPS];
    logic [DQ_W-1:0]  d_pipe_reg [STEPS];
    logic [7:0]       x_pipe_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_exp
        localparam int J = STEPS - 1 - i;
        logic [ACC_W-1:0]   acc_src;
        logic [DQ_W-1:0]    d_src;
        logic [7:0]         x_src;
        logic [2*ACC_W-1:0] mult;
        if (i == 0) begin : g_first
            assign acc_src = ACC_W'(1) << QF;
            assign d_src   = d8_reg;
            assign x_src   = x8_reg;
        end else begin : g_next
            assign acc_src = acc_reg[i-1];
            assign d_src   = d_pipe_reg[i-1];
            assign x_src   = x_pipe_reg[i-1];
        end
        assign mult = (2*ACC_W)'(acc_src) * (2*ACC_W)'(rgbca_pkg::ROOT_TAB[J]);
        always_ff @(posedge clk)
        begin
            acc_reg[i]    <= d_src[J] ? mult[QF +: ACC_W] : acc_src;
            d_pipe_reg[i] <= d_src;
            x_pipe_reg[i] <= x_src;
        end
    end

    // Stage 25: scale by 255, shift by the integer exponent, round and select.
    logic [ACC_W-1:0] acc_last;
    logic [ACC_W+7:0] scaled;
    logic [5:0]       k_out, sh_amt;
    logic [ACC_W+7:0] shifted;
    logic [9:0]       rnd;
    logic [7:0]       x_last;
    logic [7:0]       out_next, out_reg;
    always_comb
    begin
        acc_last = acc_reg[STEPS-1];
        x_last   = x_pipe_reg[STEPS-1];
        scaled   = {acc_last, 8'd0} - (ACC_W + 8)'(acc_last);
        k_out    = d_pipe_reg[STEPS-1][DQ_W-1:16];
        sh_amt   = 6'(QF - 1) + k_out;
        shifted  = scaled >> sh_amt;
        rnd      = (shifted[9:0] + 10'd1) >> 1;
        if (cfg.gamma == rgbca_pkg::GAMMA_NEUTRAL) begin
            out_next = x_last;
        end else if (x_last == 8'd0) begin
            out_next = (cfg.gamma == 9'd0) ? 8'd255 : 8'd0;
        end else if (k_out > 6'd8) begin
            // The rounded result is zero for any larger integer exponent.
            out_next = 8'd0;
        end else if (rnd > 10'd255) begin
            out_next = 8'd255;
        end else begin
            out_next = rnd[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        prod2_reg <= prod2_next;
        x2_reg    <= x1_reg;
        prod3_reg <= prod3_next;
        mag3_reg  <= mag3_next;
        neg3_reg  <= num3[18];
        x3_reg    <= x2_reg;
        x4_reg    <= x4_next;
        x5_reg    <= x5_next;
        prod6_reg <= prod6_next;
        x6_reg    <= x5_reg;
        prod7_reg <= prod7_next;
        u7_reg    <= u7_next;
        x7_reg    <= x6_reg;
        d8_reg    <= d8_next;
        x8_reg    <= x7_reg;
        out_reg   <= out_next;
    end

    assign chan_out = out_reg;

endmodule

FILE: design/rgb555_color_adjust_core.sv
// ============================================================================
// rgb555_color_adjust_core
// RGB555 to RGB888 conversion with gamma ramp, contrast, brightness and
// power-law gamma.
// ============================================================================
// The core takes one item in every clock cycle and returns its result once it
// has passed all pipeline stages, marked by a one-cycle done strobe; busy
// always reads low, and results cannot be held off. Most of the latency is
// the exp2 chain of the power-law gamma: sixteen stages, one Q30 multiply by
// a root constant in each, behind eight stages for expansion, contrast,
// brightness and the log2 scaling. Settings must only be written while no
// item is in flight.
module rgb555_color_adjust_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [rgbca_pkg::COLOR_IN_W-1:0]     color_in,
    output logic                                 done,
    output logic [rgbca_pkg::COLOR_OUT_W-1:0]    color_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rgbca_pkg::PADDR_W-1:0]        paddr,
    input  logic [rgbca_pkg::PDATA_W-1:0]        pwdata,
    output logic [rgbca_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);

    localparam int DEPTH = rgbca_pkg::PIPE_DEPTH;
    localparam int CI    = rgbca_pkg::CHAN_IN_W;
    localparam int CO    = rgbca_pkg::CHAN_OUT_W;

    logic       use_ramp_reg;
    logic [7:0] contrast_reg;
    logic [7:0] brightness_reg;
    logic [8:0] gamma_reg;
    logic       cfg_write;

    rgbca_pkg::rgbca_cfg_t cfg;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_ramp_reg   <= 1'b0;
            contrast_reg   <= rgbca_pkg::PERCENT_NEUTRAL;
            brightness_reg <= rgbca_pkg::PERCENT_NEUTRAL;
            gamma_reg      <= rgbca_pkg::GAMMA_NEUTRAL;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                rgbca_pkg::REG_USE_RAMP:   use_ramp_reg   <= pwdata[0];
                rgbca_pkg::REG_CONTRAST:   contrast_reg   <= pwdata[7:0];
                rgbca_pkg::REG_BRIGHTNESS: brightness_reg <= pwdata[7:0];
                rgbca_pkg::REG_GAMMA:      gamma_reg      <= pwdata[8:0];
                default:                   gamma_reg      <= gamma_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rgbca_pkg::REG_USE_RAMP:   prdata = 32'(use_ramp_reg);
            rgbca_pkg::REG_CONTRAST:   prdata = 32'(contrast_reg);
            rgbca_pkg::REG_BRIGHTNESS: prdata = 32'(brightness_reg);
            rgbca_pkg::REG_GAMMA:      prdata = 32'(gamma_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = '{use_ramp:   use_ramp_reg,
                   contrast:   contrast_reg,
                   brightness: brightness_reg,
                   gamma:      gamma_reg};

    // Valid bits travel alongside the channel data, one per stage.
    logic [DEPTH-1:0] valid_reg, valid_next;
    assign valid_next = {valid_reg[DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[DEPTH-1];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        rgbca_channel u_channel (
            .clk      (clk),
            .chan_in  (color_in[c*CI +: CI]),
            .cfg      (cfg),
            .chan_out (color_out[c*CO +: CO])
        );
    end

    // Every accepted item comes out after the fixed latency.
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##DEPTH done)
        else $error("accepted item did not produce a result");

    // No result appears without an item accepted the fixed latency earlier.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, DEPTH))
        else $error("result strobe without an accepted item");

    // A gamma register write lands with the masked data.
    a_gamma_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (paddr[3:2] == rgbca_pkg::REG_GAMMA))
        |=> (gamma_reg == $past(pwdata[8:0])))
        else $error("gamma register write lost");

endmodule

FILE: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench for rgb555_color_adjust_core. Pixels are sent
// through the start/busy handshake, and each result is compared with a
// bit-exact software copy of the color pipeline. Settings are changed over
// the APB port only while no item is in flight.
// ============================================================================
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SETTINGS_EACH = 10;
    localparam int ITEMS_EACH    = 50;

    localparam bit [7:0] RAMP_LUT [32] = '{
        8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
        8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
        8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
        8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [rgbca_pkg::COLOR_IN_W-1:0]  color_in = '0;
    logic                              done;
    logic [rgbca_pkg::COLOR_OUT_W-1:0] color_out;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [rgbca_pkg::PADDR_W-1:0]     paddr = '0;
    logic [rgbca_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [rgbca_pkg::PDATA_W-1:0]     prdata;
    logic                              pready;

    rgbca_pkg::rgbca_cfg_t             model_cfg;
    bit [rgbca_pkg::COLOR_OUT_W-1:0]   pending_colors [$];
    bit [rgbca_pkg::COLOR_OUT_W-1:0]   want_color;
    int                                mismatches = 0;
    int                                cycle_count = 0;
    int                                sender_idle_pct = 0;

    rgb555_color_adjust_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .color_in  (color_in),
        .done      (done),
        .color_out (color_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Color pipeline prediction
    // ------------------------------------------------------------------
    function automatic int clip_u8(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // Log2 in Q16: integer part from the top set bit, fraction by squaring.
    function automatic bit [63:0] lg2_fixed(input bit [7:0] y);
        int unsigned top;
        bit [63:0]   m;
        bit [63:0]   frac;
        top = 0;
        while (top < 7 && (y >> (top + 1)) != 0) top++;
        m = (64'(y) << 16) >> top;
        frac = '0;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 16;
            if (m >= 64'h2_0000) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(top) << 16) | frac;
    endfunction

    function automatic bit [63:0] root_floor(input bit [63:0] v);
        bit [63:0] rem;
        bit [63:0] res;
        bit [63:0] b;
        rem = v;
        res = '0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 255 * (x/255)^(g/100) through log2 and a chain of square roots of 0.5.
    function automatic bit [7:0] apply_power(input bit [7:0] x, input bit [8:0] g);
        bit [63:0] d;
        bit [63:0] k;
        bit [63:0] f;
        bit [63:0] s;
        bit [63:0] acc;
        if (x == 0) return (g == 0) ? 8'd255 : 8'd0;
        d = ((lg2_fixed(8'd255) - lg2_fixed(x)) * 64'(g) + 64'd50) / 64'd100;
        k = d >> 16;
        f = d & 64'hffff;
        if (k > 33) return 8'd0;
        s = 64'd1 << 29;
        acc = 64'd1 << 30;
        for (int j = 15; j >= 0; j--) begin
            s = root_floor(s << 30);
            if (f[j]) acc = (acc * s) >> 30;
        end
        acc = (64'd255 * acc + (64'd1 << (29 + k))) >> (30 + k);
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function automatic bit [7:0] adjust_channel(input bit [4:0] v);
        int x;
        int c;
        int q;
        x = {v, v[4:2]};
        if (model_cfg.use_ramp) x = RAMP_LUT[v];
        if (model_cfg.contrast != rgbca_pkg::PERCENT_NEUTRAL) begin
            c = int'(model_cfg.contrast) - 100;
            q = (2 * c * x + 127) / 255;
            x = clip_u8(x - c + q);
        end
        if (model_cfg.brightness != rgbca_pkg::PERCENT_NEUTRAL)
            x = clip_u8(x + int'(model_cfg.brightness) - 100);
        if (model_cfg.gamma != rgbca_pkg::GAMMA_NEUTRAL)
            x = apply_power(x[7:0], model_cfg.gamma);
        return x[7:0];
    endfunction

    function automatic bit [rgbca_pkg::COLOR_OUT_W-1:0] predict_color(
        input bit [rgbca_pkg::COLOR_IN_W-1:0] px);
        return {adjust_channel(px[14:10]), adjust_channel(px[9:5]), adjust_channel(px[4:0])};
    endfunction

    // ------------------------------------------------------------------
    // Prediction at accept, comparison at the done strobe
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && start && !busy) pending_colors.push_back(predict_color(color_in));
        if (rst_n && done) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual color_out %06h",
                         $time, color_out);
                mismatches++;
            end else begin
                want_color = pending_colors.pop_front();
                if (color_out !== want_color) begin
                    $display("%0t: color_out mismatch, expected %06h, actual %06h",
                             $time, want_color, color_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_pixel(input bit [rgbca_pkg::COLOR_IN_W-1:0] px);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            color_in <= rgbca_pkg::COLOR_IN_W'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        color_in <= px;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic wait_pipeline_empty();
        start <= 1'b0;
        do @(posedge clk); while (pending_colors.size() != 0);
    endtask

    // Every item gives a result, so an empty queue means nothing is in flight.
    task automatic write_reg(input logic [1:0] idx,
                             input logic [rgbca_pkg::PDATA_W-1:0] data);
        wait_pipeline_empty();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rgbca_pkg::REG_USE_RAMP:   model_cfg.use_ramp = data[0];
            rgbca_pkg::REG_CONTRAST:   model_cfg.contrast = data[7:0];
            rgbca_pkg::REG_BRIGHTNESS: model_cfg.brightness = data[7:0];
            rgbca_pkg::REG_GAMMA:      model_cfg.gamma = data[8:0];
            default: ;
        endcase
    endtask

    // Upper data bits beyond the register width are sometimes set; they must be dropped.
    function automatic logic [rgbca_pkg::PDATA_W-1:0] with_noise(input int unsigned val,
                                                                input int w);
        if ($urandom_range(3) == 0) return ($urandom << w) | val;
        return val;
    endfunction

    task automatic program_all(input int unsigned ramp, input int unsigned contrast,
                               input int unsigned bright, input int unsigned gamma);
        write_reg(rgbca_pkg::REG_USE_RAMP, with_noise(ramp, 1));
        write_reg(rgbca_pkg::REG_CONTRAST, with_noise(contrast, 8));
        write_reg(rgbca_pkg::REG_BRIGHTNESS, with_noise(bright, 8));
        write_reg(rgbca_pkg::REG_GAMMA, with_noise(gamma, 9));
    endtask

    function automatic int unsigned pick_setting(input int unsigned neutral,
                                                 input int unsigned legal_min,
                                                 input int unsigned legal_max,
                                                 input int unsigned span_max);
        case ($urandom_range(3))
            0: return neutral;
            1: begin
                case ($urandom_range(3))
                    0: return 0;
                    1: return legal_min;
                    2: return legal_max;
                    default: return span_max;
                endcase
            end
            default: return $urandom_range(span_max);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_defaults();
        send_pixel(15'h0000);
        send_pixel(15'h7fff);
        send_pixel(15'h7c00);
        send_pixel(15'h03e0);
        send_pixel(15'h001f);
        send_pixel(15'h5555);
        send_pixel(15'h2aaa);
    endtask

    // Each item carries three consecutive ramp indexes, so all 32 entries are hit.
    task automatic test_gamma_ramp();
        write_reg(rgbca_pkg::REG_USE_RAMP, 32'd1);
        for (int i = 0; i < 11; i++)
            send_pixel({5'(3 * i), 5'(3 * i + 1), 5'(3 * i + 2)});
        write_reg(rgbca_pkg::REG_USE_RAMP, 32'd0);
    endtask

    task automatic test_special_settings();
        // Zero exponent turns every channel white, black included.
        write_reg(rgbca_pkg::REG_GAMMA, 32'd0);
        send_pixel(15'h0000);
        send_pixel(15'h7fff);
        write_reg(rgbca_pkg::REG_GAMMA, 32'd100);
        // Contrast and brightness above the legal range still clamp.
        write_reg(rgbca_pkg::REG_CONTRAST, 32'd255);
        write_reg(rgbca_pkg::REG_BRIGHTNESS, 32'd255);
        send_pixel(15'h4210);
        write_reg(rgbca_pkg::REG_CONTRAST, 32'd0);
        write_reg(rgbca_pkg::REG_BRIGHTNESS, 32'd0);
        send_pixel(15'h7fff);
        write_reg(rgbca_pkg::REG_CONTRAST, 32'd200);
        write_reg(rgbca_pkg::REG_BRIGHTNESS, 32'd93);
        send_pixel(15'h6b5a);
        // A channel of 1 after brightness drives the exponent past its useful range.
        write_reg(rgbca_pkg::REG_CONTRAST, 32'd100);
        write_reg(rgbca_pkg::REG_GAMMA, 32'd511);
        send_pixel({5'd1, 5'd0, 5'd31});
        write_reg(rgbca_pkg::REG_GAMMA, 32'd400);
        send_pixel({5'd1, 5'd0, 5'd31});
        write_reg(rgbca_pkg::REG_GAMMA, 32'd1);
        send_pixel({5'd1, 5'd0, 5'd31});
        program_all(0, 100, 100, 100);
    endtask

    task automatic test_random_phase(input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int s = 0; s < SETTINGS_EACH; s++) begin
            if (s == 0) begin
                program_all(1, 255, 255, 511);
            end else if (s == 1) begin
                program_all(0, 0, 0, 0);
            end else begin
                program_all($urandom_range(1), pick_setting(100, 0, 200, 255),
                            pick_setting(100, 0, 200, 255), pick_setting(100, 1, 400, 511));
            end
            for (int n = 0; n < ITEMS_EACH; n++)
                send_pixel(rgbca_pkg::COLOR_IN_W'($urandom_range(32767)));
        end
    endtask

    initial begin
        model_cfg.use_ramp = 1'b0;
        model_cfg.contrast = rgbca_pkg::PERCENT_NEUTRAL;
        model_cfg.brightness = rgbca_pkg::PERCENT_NEUTRAL;
        model_cfg.gamma = rgbca_pkg::GAMMA_NEUTRAL;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 22;
        test_defaults();
        test_gamma_ramp();
        test_special_settings();
        test_random_phase(22);
        test_random_phase(79);
        test_random_phase(0);

        wait_pipeline_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_colors.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
